FILE: rtl/core/prpi_pkg.sv
// Package with the shared constants and the job record of the peak refinement point inserter.
`timescale 1ns / 1ps

package prpi_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 13;
    localparam int CNT_W        = 12;
    localparam int THR_W        = 31;
    localparam int MAX_POINTS   = 4096;
    localparam int PTS_W        = $clog2(MAX_POINTS + 1);
    localparam int INSERT_LIMIT = 4094;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 96;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One classified input item: everything the back end needs to expand it into results.
    typedef struct packed {
        logic                     mid_en;    // the middle sample is emitted
        logic                     peak;      // the middle sample is a peak with two insertions
        logic                     tail_en;   // the new sample is emitted (first or last of list)
        logic                     last;      // the new sample closes the list
        logic [IDX_W-1:0]         mid_idx;   // index of the lower inserted point or of the middle
        logic [IDX_W-1:0]         tail_idx;
        logic [CNT_W-1:0]         total;     // insertion count carried by the final result
        logic signed [DATA_W-1:0] older_e;
        logic signed [DATA_W-1:0] mid_e;
        logic signed [DATA_W-1:0] mid_v;
        logic signed [DATA_W-1:0] new_e;
        logic signed [DATA_W-1:0] new_v;
    } job_t;

endpackage

FILE: rtl/core/prpi_front.sv
// Front end: takes samples, keeps the three-sample window and classifies the middle sample.
`timescale 1ns / 1ps

module prpi_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prpi_pkg::THR_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prpi_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            job_valid,
    input  logic                            job_ready,
    output prpi_pkg::job_t                  job
);

    localparam int DW = prpi_pkg::DATA_W;
    localparam int DIFF_W = DW + 3;

    logic [prpi_pkg::THR_W-1:0]  thr_reg;
    logic signed [DW-1:0]        older_e_reg, older_v_reg, mid_e_reg, mid_v_reg;
    logic [prpi_pkg::PTS_W-1:0]  points_reg;
    logic [prpi_pkg::CNT_W-1:0]  cnt_reg;
    logic [prpi_pkg::CNT_W-1:0]  cnt_next;

    logic signed [DW-1:0]        new_e, new_v;
    logic signed [DIFF_W-1:0]    diff, diff_abs;
    logic                        have_mid, is_peak, room, insert, accept, needs_push;
    logic [prpi_pkg::PTS_W-1:0]  mid_pos;

    assign new_e = s_tdata[DW-1:0];
    assign new_v = s_tdata[2*DW-1:DW];

    // Second difference 2*mid - old - new, exact in DIFF_W bits.
    assign diff = (DIFF_W'(mid_v_reg) <<< 1) - DIFF_W'(older_v_reg) - DIFF_W'(new_v);
    assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

    assign have_mid = (points_reg >= prpi_pkg::PTS_W'(2));
    assign is_peak  = (diff_abs > $signed({{(DIFF_W-prpi_pkg::THR_W){1'b0}}, thr_reg}))
                      && (mid_v_reg > older_v_reg) && (mid_v_reg > new_v);
    assign room     = (cnt_reg <= prpi_pkg::CNT_W'(prpi_pkg::INSERT_LIMIT - 2));
    assign insert   = have_mid && is_peak && room;
    assign cnt_next = insert ? cnt_reg + prpi_pkg::CNT_W'(2) : cnt_reg;
    assign mid_pos  = points_reg - prpi_pkg::PTS_W'(1);

    // Only the second sample of a list that does not end there yields nothing.
    assign needs_push = !((points_reg == prpi_pkg::PTS_W'(1)) && !s_tlast);
    assign s_tready   = job_ready;
    assign accept     = s_tvalid && s_tready;
    assign job_valid  = s_tvalid && needs_push;

    always_comb
    begin
        job.mid_en   = have_mid;
        job.peak     = insert;
        job.tail_en  = s_tlast || (points_reg == '0);
        job.last     = s_tlast;
        job.mid_idx  = prpi_pkg::IDX_W'(mid_pos) + prpi_pkg::IDX_W'(cnt_reg);
        job.tail_idx = prpi_pkg::IDX_W'(points_reg) + prpi_pkg::IDX_W'(cnt_next);
        job.total    = s_tlast ? cnt_next : '0;
        job.older_e  = older_e_reg;
        job.mid_e    = mid_e_reg;
        job.mid_v    = mid_v_reg;
        job.new_e    = new_e;
        job.new_v    = new_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= '0;
            older_e_reg <= '0;
            older_v_reg <= '0;
            mid_e_reg   <= '0;
            mid_v_reg   <= '0;
            points_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (s_tlast)
                begin
                    older_e_reg <= '0;
                    older_v_reg <= '0;
                    mid_e_reg   <= '0;
                    mid_v_reg   <= '0;
                    points_reg  <= '0;
                    cnt_reg     <= '0;
                end
                else
                begin
                    older_e_reg <= mid_e_reg;
                    older_v_reg <= mid_v_reg;
                    mid_e_reg   <= new_e;
                    mid_v_reg   <= new_v;
                    cnt_reg     <= cnt_next;
                    if (points_reg < prpi_pkg::PTS_W'(prpi_pkg::MAX_POINTS))
                    begin
                        points_reg <= points_reg + prpi_pkg::PTS_W'(1);
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/prpi_queue.sv
// Small first-word-fall-through queue of classified jobs between front and back end.
`timescale 1ns / 1ps

module prpi_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  prpi_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output prpi_pkg::job_t  pop_job
);

    prpi_pkg::job_t                 slots_reg [prpi_pkg::QUEUE_DEPTH];
    logic [prpi_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [prpi_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != prpi_pkg::QCNT_W'(prpi_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + prpi_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + prpi_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + prpi_pkg::QCNT_W'(1);
                2'b01:   count_reg <= count_reg - prpi_pkg::QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/prpi_back.sv
// Back end: expands each job into one to four result items and drives the output register.
`timescale 1ns / 1ps

module prpi_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  prpi_pkg::job_t                  job,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prpi_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);

    localparam int DW = prpi_pkg::DATA_W;
    localparam int PAD_W = prpi_pkg::M_TDATA_W - prpi_pkg::IDX_W - 2 * DW - prpi_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_INS_LO = 4'b0001,
        ST_MID    = 4'b0010,
        ST_INS_HI = 4'b0100,
        ST_TAIL   = 4'b1000
    } step_t;

    step_t                      step_reg, step_next, start_step, step_sel;
    logic                       first_reg;
    logic                       done, emit;

    logic signed [DW-1:0]       half_a, half_b;
    logic signed [DW:0]         half_sum;
    logic                       r_kind, r_fin;
    logic [prpi_pkg::IDX_W-1:0] r_idx;
    logic signed [DW-1:0]       r_energy, r_value;
    logic [prpi_pkg::CNT_W-1:0] r_total;

    logic                       out_valid_reg, out_kind_reg, out_fin_reg;
    logic [prpi_pkg::IDX_W-1:0] out_idx_reg;
    logic signed [DW-1:0]       out_energy_reg, out_value_reg;
    logic [prpi_pkg::CNT_W-1:0] out_total_reg;

    always_comb
    begin
        if (job.peak)
        begin
            start_step = ST_INS_LO;
        end
        else if (job.mid_en)
        begin
            start_step = ST_MID;
        end
        else
        begin
            start_step = ST_TAIL;
        end
    end

    assign step_sel = first_reg ? start_step : step_reg;

    // Midpoint energy, rounded toward minus infinity by the arithmetic shift.
    assign half_a   = (step_sel == ST_INS_LO) ? job.older_e : job.mid_e;
    assign half_b   = (step_sel == ST_INS_LO) ? job.mid_e : job.new_e;
    assign half_sum = (DW + 1)'(half_a) + (DW + 1)'(half_b);

    always_comb
    begin
        r_kind    = 1'b0;
        r_idx     = job.mid_idx;
        r_energy  = job.mid_e;
        r_value   = job.mid_v;
        r_total   = '0;
        r_fin     = 1'b0;
        step_next = ST_TAIL;
        done      = 1'b1;
        unique case (step_sel)
            ST_INS_LO:
            begin
                r_kind    = 1'b1;
                r_energy  = half_sum[DW:1];
                r_value   = '0;
                step_next = ST_MID;
                done      = 1'b0;
            end
            ST_MID:
            begin
                r_idx     = job.peak ? job.mid_idx + prpi_pkg::IDX_W'(1) : job.mid_idx;
                step_next = job.peak ? ST_INS_HI : ST_TAIL;
                done      = !job.peak && !job.tail_en;
            end
            ST_INS_HI:
            begin
                r_kind    = 1'b1;
                r_idx     = job.mid_idx + prpi_pkg::IDX_W'(2);
                r_energy  = half_sum[DW:1];
                r_value   = '0;
                step_next = ST_TAIL;
                done      = !job.tail_en;
            end
            ST_TAIL:
            begin
                r_idx    = job.tail_idx;
                r_energy = job.new_e;
                r_value  = job.new_v;
                r_total  = job.total;
                r_fin    = job.last;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign emit      = job_valid && (!out_valid_reg || m_tready);
    assign job_ready = emit && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            step_reg      <= ST_TAIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                first_reg     <= done;
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg   <= r_kind;
            out_idx_reg    <= r_idx;
            out_energy_reg <= r_energy;
            out_value_reg  <= r_value;
            out_total_reg  <= r_total;
            out_fin_reg    <= r_fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_total_reg, out_value_reg, out_energy_reg, out_idx_reg};
    assign m_tlast  = out_fin_reg;
    assign m_tuser  = out_kind_reg;

endmodule

FILE: rtl/core/peak_refinement_point_inserter_unit.sv
// Top level of the peak refinement point inserter: front end, job queue and back end.
`timescale 1ns / 1ps

// The block takes a list of (energy, value) samples in Q16.16, one item per cycle at most, and
// emits the refined list: every original point plus, around each sharp peak, two inserted
// midpoint energies (at most 4094 inserted per list), each tagged with its index in the
// refined list. A middle sample is a sharp peak when its value is strictly above both
// neighbors and the absolute second difference is strictly above peak_threshold. The front
// end judges the window in the cycle a sample is taken and writes at most one job into a
// four-entry queue; the back end turns each job into one to four result items through a
// registered output. Results per sample: one for an ordinary point, three for a peak, one
// more for the last sample, none for the second. The output port, one item per cycle while
// m_tready is high, sets the sustained rate; the queue lets the input keep taking samples
// while peaks drain. The last result of a list carries tlast and the total of inserted
// points; window and counters start over when the last sample is taken. The user must write
// the threshold via cfg_we and cfg_wdata only while the block is idle; nothing enforces it.

module peak_refinement_point_inserter_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prpi_pkg::THR_W-1:0]      cfg_wdata,     // peak_threshold
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prpi_pkg::S_TDATA_W-1:0]  s_tdata,       // sample_energy, sample_value
    input  logic                            s_tlast,       // is_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prpi_pkg::M_TDATA_W-1:0]  m_tdata,       // new_index, point_energy,
                                                           // point_value, inserted_total, pad
    output logic                            m_tlast,       // final_result
    output logic                            m_tuser        // point_kind
);

    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    prpi_pkg::job_t fq_job, qb_job;

    // The front end classifies each sample and owns the window and the counters.
    prpi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // The queue decouples the two sides so a peak expansion does not stall the input at once.
    prpi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // The back end sequences the result items of each job onto the output register.
    prpi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
